>>> rtl/two_level_page_table_engine_top_defines.svh
// Assertion macros used by the page table engine RTL (tlpt_back).
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// lbl: antecedent implies consequent in the same cycle
`define TLPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlpt assertion failed");
// lbl: antecedent implies consequent in the next cycle
`define TLPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlpt assertion failed");
`else
`define TLPT_ASSERT_SAME(lbl, ante, cons)
`define TLPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/tlpt_pkg.sv
package tlpt_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int DIR_W         = $clog2(DIR_ENTRIES);
  localparam int TBL_W         = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W        = DIR_W + TBL_W;
  localparam int TBL_SLOTS     = DIR_ENTRIES * TABLE_ENTRIES;
  localparam int OFF_W         = 12;
  localparam int FRAME_W       = 20;
  localparam int DIR_SHIFT     = 22;
  localparam int PAGE_SHIFT    = 12;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_XLATE = 2'd2;

  // decoded operation handed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic [DIR_W-1:0]   dir_idx;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] frame;
    logic [OFF_W-1:0]   offset;
  } entry_t;

  // stored table entry: present bit and frame
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  typedef struct packed {
    logic q_full;
    logic clearing;
  } ctl_t;

  typedef struct packed {
    logic   empty;
    entry_t head;
  } q_head_t;

endpackage

>>> rtl/tlpt_if.sv
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] virtual_addr;
  logic [31:0] physical_addr;
  logic [2:0]  map_flags;

  modport source(output valid, opcode, virtual_addr, physical_addr, map_flags,
                 input ready);
  modport sink(input valid, opcode, virtual_addr, physical_addr, map_flags,
               output ready);
endinterface

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] phys_result;
  logic        hit;

  modport source(output valid, phys_result, hit, input ready);
  modport sink(input valid, phys_result, hit, output ready);
endinterface

>>> rtl/two_level_page_table_engine_top.sv
// Two-level 10/10/12 page table: map, unmap and translate.
// Sustained rate one transaction per cycle while the response side takes results;
// a translate result passes the queue, the memory read and the output register.
// Map, unmap and opcode 3 give no result.
// After reset a clearing pass over all 1048576 table slots zeroes both tables;
// no transaction is accepted until it ends.
module two_level_page_table_engine_top #(
  parameter int QUEUE_DEPTH = tlpt_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  tlpt_req_if.sink   req,
  tlpt_rsp_if.source rsp
);
  import tlpt_pkg::*;

  ctl_t    ctl;
  q_head_t head;
  entry_t  push_entry;
  logic    push, pop, q_full, clearing;

  assign ctl.q_full   = q_full;
  assign ctl.clearing = clearing;

  tlpt_front u_front (
    .req        (req),
    .ctl        (ctl),
    .push       (push),
    .push_entry (push_entry)
  );

  tlpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full)
  );

  tlpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );
endmodule

>>> rtl/tlpt_front.sv
module tlpt_front (
  tlpt_req_if.sink         req,
  input  tlpt_pkg::ctl_t   ctl,
  output logic             push,
  output tlpt_pkg::entry_t push_entry
);
  import tlpt_pkg::*;

  logic known_op;

  assign req.ready = !ctl.q_full && !ctl.clearing;

  // opcode 3 is accepted and dropped here
  always_comb begin
    unique case (req.opcode)
      OP_MAP, OP_UNMAP, OP_XLATE: known_op = 1'b1;
      default:                    known_op = 1'b0;
    endcase
  end

  assign push = req.valid && req.ready && known_op;

  // write and user flags never reach a result, so they are not carried
  assign push_entry.op      = req.opcode;
  assign push_entry.dir_idx = req.virtual_addr[DIR_SHIFT +: DIR_W];
  assign push_entry.slot    = req.virtual_addr[PAGE_SHIFT +: SLOT_W];
  assign push_entry.frame   = req.physical_addr[PAGE_SHIFT +: FRAME_W];
  assign push_entry.offset  = req.virtual_addr[OFF_W-1:0];
endmodule

>>> rtl/tlpt_queue.sv
module tlpt_queue #(
  parameter int DEPTH = tlpt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tlpt_pkg::entry_t  push_entry,
  input  logic              pop,
  output tlpt_pkg::q_head_t head,
  output logic              full
);
  import tlpt_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head.empty = count == '0;
  assign head.head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

>>> rtl/tlpt_back.sv
module tlpt_back (
  input  logic              clk,
  input  logic              rst,
  input  tlpt_pkg::q_head_t head,
  output logic              pop,
  output logic              clearing,
  tlpt_rsp_if.source        rsp
);
  import tlpt_pkg::*;
  `include "two_level_page_table_engine_top_defines.svh"

  logic              dir_mem [DIR_ENTRIES];
  pte_t              tbl_mem [TBL_SLOTS];
  logic [SLOT_W-1:0] clear_cnt;

  logic              tbl_we, dir_we, dir_wd, rd_en;
  logic [SLOT_W-1:0] tbl_wa;
  pte_t              tbl_wd;
  logic [DIR_W-1:0]  dir_wa;

  logic              rd_valid, rd_adv;
  logic [OFF_W-1:0]  rd_off;
  logic              dir_q;
  pte_t              tbl_q;

  logic              out_valid, out_hit;
  logic [31:0]       out_phys;
  logic              lookup_hit;

  assign rd_adv = rd_valid && (!out_valid || rsp.ready);
  assign pop    = !head.empty && !clearing && (!rd_valid || rd_adv);

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = head.head.slot;
    tbl_wd = '0;
    dir_we = 1'b0;
    dir_wa = head.head.dir_idx;
    dir_wd = 1'b0;
    rd_en  = 1'b0;
    if (clearing) begin
      tbl_we = 1'b1;
      tbl_wa = clear_cnt;
      dir_we = 1'b1;
      dir_wa = clear_cnt[DIR_W-1:0];
    end else if (pop) begin
      unique case (head.head.op)
        OP_MAP: begin
          tbl_we = 1'b1;
          tbl_wd = '{present: 1'b1, frame: head.head.frame};
          dir_we = 1'b1;
          dir_wd = 1'b1;
        end
        OP_UNMAP: tbl_we = 1'b1;
        OP_XLATE: rd_en = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
  end

  // read data holds while the lookup waits on the output register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      dir_q  <= dir_mem[head.head.dir_idx];
      tbl_q  <= tbl_mem[head.head.slot];
      rd_off <= head.head.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
    end else if (clearing) begin
      clear_cnt <= clear_cnt + 1'b1;
      if (clear_cnt == SLOT_W'(TBL_SLOTS - 1)) clearing <= 1'b0;
    end
  end

  assign lookup_hit = dir_q && tbl_q.present;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en)       rd_valid <= 1'b1;
      else if (rd_adv) rd_valid <= 1'b0;
      if (rd_adv)         out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_adv) begin
      out_hit  <= lookup_hit;
      out_phys <= lookup_hit ? {tbl_q.frame, rd_off} : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.phys_result = out_phys;

  `TLPT_ASSERT_SAME(a_no_pop_clearing, clearing, !pop)
  `TLPT_ASSERT_NEXT(a_lookup_held, rd_valid && !rd_adv, rd_valid && $stable(rd_off))
  `TLPT_ASSERT_SAME(a_miss_zero, out_valid && !out_hit, out_phys == '0)
  `TLPT_ASSERT_SAME(a_no_read_stalled, rd_valid && !rd_adv, !rd_en)
endmodule

>>> tb/two_level_page_table_engine_top_tb.sv
module two_level_page_table_engine_top_tb;
  import tlpt_pkg::*;

  localparam logic [1:0] OP_RSVD     = 2'd3;
  localparam int         RAND_ITEMS  = 400;
  localparam int         POOL_PAGES  = 12;
  // clearing pass after reset plus a wide margin for traffic and stalls
  localparam int         CYCLE_LIMIT = TBL_SLOTS + 200000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic [2:0]  flags;
  } page_op_t;

  typedef struct {
    logic [31:0] paddr;
    logic        hit;
  } xlate_t;

  // stored entry: user, write, present, frame
  typedef struct packed {
    logic               user;
    logic               wr;
    logic               present;
    logic [FRAME_W-1:0] frame;
  } pt_entry_t;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic clk;
  logic rst;

  tlpt_req_if req_if ();
  tlpt_rsp_if rsp_if ();

  two_level_page_table_engine_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  page_op_t  page_op_q[$];
  xlate_t    xlate_expect_q[$];
  bit        dir_present [DIR_ENTRIES];
  pt_entry_t page_table [bit [SLOT_W-1:0]];
  int        err_cnt;
  int        cycle_cnt;
  int        burst_left;
  int        idle_left;
  rx_mode_t  rx_mode;
  int        rx_mode_left;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("ERROR @%0t: %s got 0x%08h expected 0x%08h", $time, what, got, exp);
    err_cnt++;
  endtask

  // apply one accepted transaction to the shadow tables; translates queue a result
  task automatic walk_page_table(page_op_t t);
    logic [SLOT_W-1:0] slot;
    logic [DIR_W-1:0]  dir;
    pt_entry_t         e;
    xlate_t            x;
    slot = t.vaddr[31:PAGE_SHIFT];
    dir  = t.vaddr[31:DIR_SHIFT];
    e    = page_table.exists(slot) ? page_table[slot] : '0;
    case (t.op)
      OP_MAP: begin
        e.present = 1'b1;
        e.frame   = t.paddr[31:PAGE_SHIFT];
        e.wr      = t.flags[1];
        e.user    = t.flags[2];
        page_table[slot] = e;
        dir_present[dir] = 1'b1;
      end
      OP_UNMAP: begin
        // flags survive an unmap
        e.present = 1'b0;
        e.frame   = '0;
        page_table[slot] = e;
      end
      OP_XLATE: begin
        x.hit   = dir_present[dir] && e.present;
        x.paddr = x.hit ? {e.frame, t.vaddr[OFF_W-1:0]} : 32'h0;
        xlate_expect_q.push_back(x);
      end
      default: ;
    endcase
  endtask

  task automatic add_op(logic [1:0] op, logic [31:0] va, logic [31:0] pa, logic [2:0] fl);
    page_op_t t;
    t.op    = op;
    t.vaddr = va;
    t.paddr = pa;
    t.flags = fl;
    page_op_q.push_back(t);
  endtask

  // request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    page_op_t t;
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left   <= 0;
      idle_left    <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        t.op    = req_if.opcode;
        t.vaddr = req_if.virtual_addr;
        t.paddr = req_if.physical_addr;
        t.flags = req_if.map_flags;
        walk_page_table(t);
      end
      if (!req_if.valid || req_if.ready) begin
        if (idle_left != 0) begin
          idle_left    <= idle_left - 1;
          req_if.valid <= 1'b0;
        end else if (page_op_q.size() != 0) begin
          t = page_op_q.pop_front();
          req_if.valid         <= 1'b1;
          req_if.opcode        <= t.op;
          req_if.virtual_addr  <= t.vaddr;
          req_if.physical_addr <= t.paddr;
          req_if.map_flags     <= t.flags;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response sink: stall behavior switches between modes at random intervals
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rx_mode      <= RX_FREE;
      rx_mode_left <= 50;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 2));
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:   rsp_if.ready <= 1'b1;
        RX_CHOPPY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default:   rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    xlate_t x;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (xlate_expect_q.size() == 0) begin
        report_mismatch("unexpected result, phys_result", rsp_if.phys_result, 32'h0);
      end else begin
        x = xlate_expect_q.pop_front();
        if (rsp_if.phys_result !== x.paddr)
          report_mismatch("phys_result", rsp_if.phys_result, x.paddr);
        if (rsp_if.hit !== x.hit)
          report_mismatch("hit", {31'h0, rsp_if.hit}, {31'h0, x.hit});
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [19:0]  vpn_pool [POOL_PAGES];
    logic [9:0]   dir_pick [4];
    logic [31:0]  rnd;
    logic [31:0]  va;
    logic [1:0]   op;
    int           n;
    int           r;
    int           k;

    err_cnt              = 0;
    cycle_cnt            = 0;
    rst                  = 1'b1;
    req_if.valid         = 1'b0;
    req_if.opcode        = OP_MAP;
    req_if.virtual_addr  = '0;
    req_if.physical_addr = '0;
    req_if.map_flags     = '0;
    rsp_if.ready         = 1'b0;

    // directed: empty tables, extremes, remap, forwarding, reserved opcode
    add_op(OP_XLATE, 32'h0000_0000, 32'h0, 3'd0);
    add_op(OP_XLATE, 32'hFFFF_FFFF, 32'h0, 3'd0);
    add_op(OP_UNMAP, 32'h0040_0000, 32'h0, 3'd0);
    add_op(OP_XLATE, 32'h0040_0000, 32'h0, 3'd0);
    add_op(OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 3'd7);
    add_op(OP_XLATE, 32'h0000_0FFF, 32'h0, 3'd0);
    add_op(OP_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 3'd0);
    add_op(OP_XLATE, 32'hFFFF_FFFF, 32'h0, 3'd0);
    add_op(OP_XLATE, 32'hFFC0_0000, 32'h0, 3'd0);
    add_op(OP_MAP,   32'h0000_1234, 32'h1234_5ABC, 3'd2);
    add_op(OP_XLATE, 32'h0000_1ABC, 32'h0, 3'd0);
    add_op(OP_MAP,   32'h0000_1000, 32'hABCD_E000, 3'd4);
    add_op(OP_XLATE, 32'h0000_1000, 32'h0, 3'd0);
    add_op(OP_UNMAP, 32'h0000_1FFF, 32'h0, 3'd0);
    add_op(OP_XLATE, 32'h0000_1555, 32'h0, 3'd0);
    add_op(OP_UNMAP, 32'h0000_1000, 32'h0, 3'd0);
    add_op(OP_RSVD,  32'h0000_0000, 32'h0000_5555, 3'd1);
    add_op(OP_XLATE, 32'h0000_0000, 32'h0, 3'd0);
    add_op(OP_MAP,   32'h8000_0000, 32'h8000_0FFF, 3'd6);
    add_op(OP_XLATE, 32'h8000_0800, 32'h0, 3'd0);
    add_op(OP_RSVD,  32'h8000_0000, 32'hFFFF_FFFF, 3'd7);
    add_op(OP_XLATE, 32'h8000_07FF, 32'h0, 3'd0);
    add_op(OP_MAP,   32'h0000_1000, 32'h5555_5000, 3'd1);
    add_op(OP_XLATE, 32'h0000_1AAA, 32'h0, 3'd0);

    // small page pool so maps, unmaps and translates collide often
    dir_pick[0] = 10'd0;
    dir_pick[1] = 10'h3FF;
    dir_pick[2] = 10'($urandom());
    dir_pick[3] = 10'($urandom());
    for (k = 0; k < POOL_PAGES; k++)
      vpn_pool[k] = {dir_pick[k % 4], 10'($urandom())};

    n = 0;
    while (n < RAND_ITEMS) begin
      rnd = $urandom();
      r   = $urandom_range(0, 99);
      if (r < 30)      op = OP_MAP;
      else if (r < 45) op = OP_UNMAP;
      else if (r < 95) op = OP_XLATE;
      else             op = OP_RSVD;
      r = $urandom_range(0, 99);
      if (r < 85)
        va = {vpn_pool[$urandom_range(0, POOL_PAGES - 1)], rnd[11:0]};
      else if (r < 93)
        va = {dir_pick[$urandom_range(0, 3)], rnd[21:0]};
      else
        va = rnd;
      add_op(op, va, $urandom(), 3'($urandom()));
      if (op != OP_RSVD)
        n++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (page_op_q.size() != 0 || req_if.valid || xlate_expect_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
